// File: rtl/differential_drive_odometry_assert.svh
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH

// condition checked in the same cycle as the trigger
`define ODO_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition checked in the cycle after the trigger
`define ODO_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/odo_pkg.sv
package odo_pkg;

  localparam int POSE_WIDTH_DEF  = 48;
  localparam int ANGLE_WIDTH_DEF = 32;

  localparam int TRACK_W  = 24;
  localparam int POS_W    = 32;
  localparam int EPOCH_W  = 8;
  localparam int SET_W    = 48;

  // input tdata layout
  localparam int OFF_LP     = 0;
  localparam int OFF_RP     = 32;
  localparam int OFF_LE     = 64;
  localparam int OFF_RE     = 72;
  localparam int OFF_SX     = 80;
  localparam int OFF_SY     = 128;
  localparam int OFF_SH     = 176;
  localparam int IN_TDATA_W = 208;

  localparam logic [TRACK_W-1:0] TRACK_RESET = 24'd40960;
  localparam logic [31:0]        TWO_PI_Q29  = 32'd3373259426;

  localparam int MAG_W      = 34;
  localparam int TURN_SHIFT = 29;
  localparam int DIST_W     = 33;
  localparam int CS_W       = 33;
  localparam int Z_W        = 34;
  localparam int ACC_W      = 66;
  localparam int REM_W      = 56;
  localparam int STEP_W     = 7;
  localparam int CORDIC_STEPS = 30;

  localparam logic signed [CS_W-1:0] CORDIC_GAIN = 33'sd652032874;

  typedef struct packed {
    logic              capture;
    logic              prep;
    logic              div_step;
    logic              cord_init;
    logic              cord_step;
    logic              mul_step;
    logic              apply;
    logic              load_out;
    logic [STEP_W-1:0] step;
  } odo_cmd_t;

  typedef struct packed {
    logic is_reset;
  } odo_sts_t;

  // arctangent of 2^-i as a 32-bit binary angle
  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/differential_drive_odometry.sv
// wheel update: the item is captured, then passes through prep, the bit-serial heading divider
// (63 + ANGLE_WIDTH steps), cordic init, the 30-step cordic, the multiply steps and apply
// before the result is loaded; no new item is taken until the result is loaded
// pose reset item: prep loads the set pose, then the result is loaded
// rst is synchronous: pose, path, baselines and epochs clear, track_width returns to 40960
module differential_drive_odometry import odo_pkg::*; #(
  parameter int POSE_WIDTH  = POSE_WIDTH_DEF,
  parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // left_position, right_position, left_epoch, right_epoch, set_x, set_y, set_heading
  input  logic [IN_TDATA_W-1:0] s_tdata,
  // kind
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // pos_x, pos_y, heading, path_length, zero fill
  output logic [((3*POSE_WIDTH+ANGLE_WIDTH+7)/8)*8-1:0] m_tdata,
  input  logic                  cfg_wr_en,
  input  logic [TRACK_W-1:0]    cfg_wr_data
);

  odo_cmd_t cmd;
  odo_sts_t sts;

  odo_ctrl #(
    .ANGLE_WIDTH(ANGLE_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  odo_dp #(
    .POSE_WIDTH (POSE_WIDTH),
    .ANGLE_WIDTH(ANGLE_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .m_tdata     (m_tdata)
  );

endmodule

// File: rtl/odo_ctrl.sv
module odo_ctrl import odo_pkg::*; #(
  parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  output logic     m_tvalid,
  input  logic     m_tready,
  input  odo_sts_t sts,
  output odo_cmd_t cmd
);

  localparam int DIV_STEPS = MAG_W + TURN_SHIFT + ANGLE_WIDTH;
  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(DIV_STEPS - 1);
  localparam logic [STEP_W-1:0] CORD_LAST = STEP_W'(CORDIC_STEPS - 1);
  localparam logic [STEP_W-1:0] MUL_LAST  = STEP_W'(3);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_CINIT = 3'd3;
  localparam logic [2:0] S_CORD  = 3'd4;
  localparam logic [2:0] S_MUL   = 3'd5;
  localparam logic [2:0] S_APPLY = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]        state, state_next;
  logic [STEP_W-1:0] step, step_next;

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    cmd.step   = step;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        step_next  = '0;
        state_next = sts.is_reset ? S_OUT : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step == DIV_LAST) begin
          step_next  = '0;
          state_next = S_CINIT;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end
      S_CINIT: begin
        cmd.cord_init = 1'b1;
        state_next    = S_CORD;
      end
      S_CORD: begin
        cmd.cord_step = 1'b1;
        if (step == CORD_LAST) begin
          step_next  = '0;
          state_next = S_MUL;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (step == MUL_LAST) begin
          step_next  = '0;
          state_next = S_APPLY;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        // wait until the output register is free
        if (!m_tvalid || m_tready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign s_tready = (state == S_IDLE);

endmodule

// File: rtl/odo_dp.sv
module odo_dp import odo_pkg::*; #(
  parameter int POSE_WIDTH  = POSE_WIDTH_DEF,
  parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  odo_cmd_t              cmd,
  output odo_sts_t              sts,
  input  logic [IN_TDATA_W-1:0] s_tdata,
  input  logic                  s_tuser,
  input  logic                  cfg_wr_en,
  input  logic [TRACK_W-1:0]    cfg_wr_data,
  output logic [((3*POSE_WIDTH+ANGLE_WIDTH+7)/8)*8-1:0] m_tdata
);

  localparam int PW     = POSE_WIDTH;
  localparam int AW     = ANGLE_WIDTH;
  localparam int OUT_W  = ((3*PW + AW + 7) / 8) * 8;
  localparam int NW     = MAG_W + TURN_SHIFT + AW;
  localparam int EW     = ((PW > SET_W) ? PW : SET_W) + 2;
  localparam int PSW    = ((PW > DIST_W) ? PW : DIST_W) + 1;
  localparam int STEP_XW = ACC_W - 30;

  localparam logic signed [EW-1:0] PMAX  = (EW'(1) <<< (PW - 1)) - EW'(1);
  localparam logic signed [EW-1:0] PMIN  = -PMAX - EW'(1);
  localparam logic [PW-1:0]        PMASK = {PW{1'b1}};

  function automatic logic [PW-1:0] sat_pw(input logic signed [EW-1:0] v);
    logic [PW-1:0] r;
    if (v > PMAX) begin
      r = PMAX[PW-1:0];
    end else if (v < PMIN) begin
      r = PMIN[PW-1:0];
    end else begin
      r = v[PW-1:0];
    end
    return r;
  endfunction

  // captured item
  logic                      in_kind;
  logic signed [POS_W-1:0]   in_lp, in_rp;
  logic [EPOCH_W-1:0]        in_le, in_re;
  logic signed [SET_W-1:0]   in_sx, in_sy;
  logic [AW-1:0]             in_sh;

  // architectural state
  logic [TRACK_W-1:0]        track;
  logic signed [PW-1:0]      pose_x, pose_y;
  logic [AW-1:0]             pose_heading;
  logic [PW-1:0]             total_path;
  logic signed [POS_W-1:0]   left_base, right_base;
  logic [EPOCH_W-1:0]        left_epoch, right_epoch;

  // working registers
  logic signed [DIST_W-1:0]  travel;
  logic                      neg, tz;
  logic [REM_W-1:0]          dvs, rem;
  logic [NW-1:0]             num;
  logic [AW:0]               quo;
  logic                      flip;
  logic signed [CS_W-1:0]    cx, cy;
  logic signed [Z_W-1:0]     cz;
  logic signed [ACC_W-1:0]   acc_x, acc_y;
  logic [OUT_W-1:0]          out_data;

  // wheel travel
  logic signed [DIST_W-1:0]  dl, dr;
  logic signed [MAG_W-1:0]   dsum, diff;
  logic [MAG_W-1:0]          mag;

  always_comb begin
    dl   = (in_le != left_epoch)  ? '0 : (DIST_W'(in_lp) - DIST_W'(left_base));
    dr   = (in_re != right_epoch) ? '0 : (DIST_W'(in_rp) - DIST_W'(right_base));
    dsum = MAG_W'(dl) + MAG_W'(dr);
    diff = MAG_W'(dr) - MAG_W'(dl);
    mag  = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
  end

  // divider step
  logic [REM_W:0] trial;
  logic           ge;
  assign trial = {rem, num[NW-1]};
  assign ge    = (trial >= {1'b0, dvs});

  // turn and half turn
  logic [AW-1:0] half, dth, ang;
  logic [31:0]   a32;
  logic          flip_c;
  always_comb begin
    half   = tz ? '0 : (neg ? AW'(-quo[AW:1]) : quo[AW:1]);
    dth    = tz ? '0 : (neg ? AW'(-quo[AW-1:0]) : quo[AW-1:0]);
    ang    = pose_heading + half;
    a32    = 32'(ang) << (32 - AW);
    flip_c = a32[31] ^ a32[30];
  end

  // cordic step
  logic [4:0]             ci;
  logic signed [CS_W-1:0] xs, ys;
  logic signed [Z_W-1:0]  atan_z;
  always_comb begin
    ci     = cmd.step[4:0];
    xs     = cx >>> ci;
    ys     = cy >>> ci;
    atan_z = $signed({2'b00, atan_lut(ci)});
  end

  // partial products of travel * cos and travel * sin
  logic signed [CS_W-1:0]  cq, sq, cs_sel;
  logic signed [16:0]      part;
  logic signed [49:0]      prod;
  logic signed [ACC_W-1:0] prod_ext, prod_sh;
  always_comb begin
    cq       = flip ? -cx : cx;
    sq       = flip ? -cy : cy;
    cs_sel   = cmd.step[1] ? sq : cq;
    part     = cmd.step[0] ? $signed({cs_sel[31], cs_sel[31:16]})
                           : $signed({1'b0, cs_sel[15:0]});
    prod     = 50'(travel) * 50'(part);
    prod_ext = ACC_W'(prod);
    prod_sh  = cmd.step[0] ? (prod_ext <<< 16) : prod_ext;
  end

  // final accumulation
  logic signed [STEP_XW-1:0] step_x, step_y;
  logic signed [EW-1:0]      sum_x, sum_y;
  logic [DIST_W-1:0]         adist;
  logic [PSW-1:0]            psum;
  always_comb begin
    step_x = acc_x[ACC_W-1:30];
    step_y = acc_y[ACC_W-1:30];
    sum_x  = EW'(pose_x) + EW'(step_x);
    sum_y  = EW'(pose_y) + EW'(step_y);
    adist  = travel[DIST_W-1] ? DIST_W'(-travel) : DIST_W'(travel);
    psum   = PSW'(total_path) + PSW'(adist);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      track        <= TRACK_RESET;
      pose_x       <= '0;
      pose_y       <= '0;
      pose_heading <= '0;
      total_path   <= '0;
      left_base    <= '0;
      right_base   <= '0;
      left_epoch   <= '0;
      right_epoch  <= '0;
    end else begin
      if (cfg_wr_en) begin
        track <= cfg_wr_data;
      end
      if (cmd.prep) begin
        left_base  <= in_lp;
        right_base <= in_rp;
        if (in_kind) begin
          pose_x       <= sat_pw(EW'(in_sx));
          pose_y       <= sat_pw(EW'(in_sy));
          pose_heading <= in_sh;
        end else begin
          left_epoch  <= in_le;
          right_epoch <= in_re;
        end
      end
      if (cmd.apply) begin
        pose_x       <= sat_pw(sum_x);
        pose_y       <= sat_pw(sum_y);
        pose_heading <= pose_heading + dth;
        total_path   <= (psum > PSW'(PMASK)) ? PMASK : psum[PW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_kind <= s_tuser;
      in_lp   <= s_tdata[OFF_LP +: POS_W];
      in_rp   <= s_tdata[OFF_RP +: POS_W];
      in_le   <= s_tdata[OFF_LE +: EPOCH_W];
      in_re   <= s_tdata[OFF_RE +: EPOCH_W];
      in_sx   <= s_tdata[OFF_SX +: SET_W];
      in_sy   <= s_tdata[OFF_SY +: SET_W];
      in_sh   <= s_tdata[OFF_SH +: AW];
    end
    if (cmd.prep) begin
      travel <= dsum[MAG_W-1:1];
      neg    <= diff[MAG_W-1];
      tz     <= (track == '0);
      dvs    <= REM_W'(track) * REM_W'(TWO_PI_Q29);
      num    <= NW'(mag) << (TURN_SHIFT + AW);
      rem    <= '0;
      quo    <= '0;
    end
    if (cmd.div_step) begin
      rem <= ge ? REM_W'(trial - {1'b0, dvs}) : REM_W'(trial);
      num <= num << 1;
      quo <= {quo[AW-1:0], ge};
    end
    if (cmd.cord_init) begin
      flip <= flip_c;
      cx   <= CORDIC_GAIN;
      cy   <= '0;
      cz   <= Z_W'($signed({a32[31] ^ flip_c, a32[30:0]}));
    end
    if (cmd.cord_step) begin
      if (!cz[Z_W-1]) begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - atan_z;
      end else begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + atan_z;
      end
    end
    if (cmd.mul_step) begin
      if (cmd.step[1]) begin
        acc_y <= cmd.step[0] ? (acc_y + prod_sh) : prod_sh;
      end else begin
        acc_x <= cmd.step[0] ? (acc_x + prod_sh) : prod_sh;
      end
    end
    if (cmd.load_out) begin
      out_data <= OUT_W'({total_path, pose_heading, pose_y, pose_x});
    end
  end

  assign sts.is_reset = in_kind;
  assign m_tdata      = out_data;

endmodule

// File: rtl/odo_checker.sv
module odo_checker #(
  parameter int TDATA_W = 176
) (
  input logic               clk,
  input logic               rst,
  input logic               s_tvalid,
  input logic               s_tready,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [TDATA_W-1:0] m_tdata
);

`include "differential_drive_odometry_assert.svh"

  `ODO_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
  `ODO_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")
  `ODO_ASSERT_NEXT(a_busy_after_in, s_tvalid && s_tready, !s_tready, "second item taken while busy")
  `ODO_ASSERT_NEXT(a_no_early_out, s_tvalid && s_tready, !$rose(m_tvalid), "result before work done")

endmodule

bind differential_drive_odometry odo_checker #(
  .TDATA_W(((3*POSE_WIDTH+ANGLE_WIDTH+7)/8)*8)
) u_odo_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
